>>> hw/rtl/mbt_pkg.sv
// Shared types, codes and constants of the mouse button click and drag tracker.
`timescale 1ns / 1ps

package mbt_pkg;

	localparam int NUM_BUTTONS = 6;

	// Input command codes.
	localparam logic [2:0] CMD_DOWN   = 3'd0;
	localparam logic [2:0] CMD_UP     = 3'd1;
	localparam logic [2:0] CMD_MOTION = 3'd2;
	localparam logic [2:0] CMD_TICK   = 3'd3;
	localparam logic [2:0] CMD_FOCUS  = 3'd4;
	localparam logic [2:0] CMD_STATUS = 3'd5;

	// Button phase codes as reported on the result side.
	localparam logic [2:0] PH_UP       = 3'd0;
	localparam logic [2:0] PH_PRESSED  = 3'd1;
	localparam logic [2:0] PH_DOWN     = 3'd2;
	localparam logic [2:0] PH_RELEASED = 3'd3;
	localparam logic [2:0] PH_PRESSREL = 3'd4;
	localparam logic [2:0] PH_DCLICK   = 3'd5;
	localparam logic [2:0] PH_DRAG     = 3'd6;

	localparam logic [2:0] BTN_MIDDLE      = 3'd2;
	localparam logic [2:0] BTN_WHEEL_UP    = 3'd4;
	localparam logic [2:0] BTN_WHEEL_DOWN  = 3'd5;
	localparam logic [2:0] BTN_FIRST_WHEEL = 3'd4;

	// Configuration register indexes.
	localparam logic CFG_INTERVAL  = 1'b0;
	localparam logic CFG_THRESHOLD = 1'b1;

	localparam logic [15:0] INTERVAL_RST  = 16'd250;
	localparam logic [15:0] THRESHOLD_RST = 16'd5;
	localparam logic [2:0]  DRAG_BTN_RST  = 3'd1;

	typedef enum logic [2:0] {
		OP_DOWN,
		OP_UP,
		OP_MOTION,
		OP_TICK,
		OP_FOCUS,
		OP_STATUS
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [2:0]  button;
		logic        btn_valid;
		logic [31:0] event_time;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
	} item_t;

	typedef struct packed {
		logic [2:0]  button_phase;
		logic        is_down;
		logic        went_down;
		logic        went_up;
		logic        double_clicked;
		logic        dragging;
		logic [15:0] drag_start_x;
		logic [15:0] drag_start_y;
		logic [15:0] pointer_x;
		logic [15:0] pointer_y;
	} result_t;

endpackage

>>> hw/rtl/mbt_front.sv
// Front end: accepts events, classifies them and holds them in a two-entry queue.
`timescale 1ns / 1ps

module mbt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [2:0]     command,
	input  logic [2:0]     button,
	input  logic [31:0]    event_time,
	input  logic [15:0]    pos_x,
	input  logic [15:0]    pos_y,
	output logic           item_empty,
	input  logic           item_pop,
	output mbt_pkg::item_t item
);
	import mbt_pkg::*;

	item_t      slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	item_t      decoded;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		decoded.button     = button;
		decoded.btn_valid  = ({1'b0, button} < 4'(NUM_BUTTONS));
		decoded.event_time = event_time;
		decoded.pos_x      = pos_x;
		decoded.pos_y      = pos_y;
		unique case (command)
			CMD_DOWN:   decoded.op = OP_DOWN;
			CMD_UP:     decoded.op = OP_UP;
			CMD_MOTION: decoded.op = OP_MOTION;
			CMD_TICK:   decoded.op = OP_TICK;
			CMD_FOCUS:  decoded.op = OP_FOCUS;
			CMD_STATUS: decoded.op = OP_STATUS;
			default:    decoded.op = OP_STATUS;
		endcase
	end

	assign full       = (count_q == 2'd2);
	assign item_empty = (count_q == 2'd0);
	assign do_push    = push && !full;
	assign do_pop     = item_pop && !item_empty;
	assign item       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/mbt_back.sv
// Back end: button phase state, event execution and the two-entry result queue.
`timescale 1ns / 1ps

module mbt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             item_empty,
	output logic             item_pop,
	input  mbt_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output mbt_pkg::result_t result
);
	import mbt_pkg::*;

	logic [15:0] interval_q;
	logic [15:0] threshold_q;
	logic [2:0]  phase_q [NUM_BUTTONS];
	logic [31:0] press_q [NUM_BUTTONS];
	logic [15:0] cur_x_q;
	logic [15:0] cur_y_q;
	logic [2:0]  drag_btn_q;
	logic [15:0] start_x_q;
	logic [15:0] start_y_q;

	logic [2:0]  phase_d [NUM_BUTTONS];
	logic [31:0] press_d [NUM_BUTTONS];
	logic [15:0] cur_x_d;
	logic [15:0] cur_y_d;
	logic [2:0]  drag_btn_d;
	logic [15:0] start_x_d;
	logic [15:0] start_y_d;

	logic [31:0] press_sel;
	logic [31:0] elapsed;
	logic        within_interval;
	logic [15:0] dx;
	logic [15:0] dy;
	logic        moved_far;
	logic [2:0]  res_phase;
	result_t     res;

	result_t     slot_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  count_q;
	logic        take;
	logic        do_pop;

	// Press time of the addressed button, for the double-click window.
	always_comb begin
		press_sel = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (item.button == 3'(i)) begin
				press_sel = press_q[i];
			end
		end
	end

	assign elapsed         = item.event_time - press_sel;
	assign within_interval = (elapsed < {16'd0, interval_q});
	assign dx = (start_x_q > item.pos_x) ? start_x_q - item.pos_x : item.pos_x - start_x_q;
	assign dy = (start_y_q > item.pos_y) ? start_y_q - item.pos_y : item.pos_y - start_y_q;
	assign moved_far = (dx > threshold_q) || (dy > threshold_q);

	always_comb begin
		phase_d    = phase_q;
		press_d    = press_q;
		cur_x_d    = cur_x_q;
		cur_y_d    = cur_y_q;
		drag_btn_d = drag_btn_q;
		start_x_d  = start_x_q;
		start_y_d  = start_y_q;
		case (item.op)
			OP_DOWN: begin
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					if (item.btn_valid && item.button == 3'(i) &&
					    (phase_q[i] == PH_UP || phase_q[i] == PH_RELEASED ||
					     phase_q[i] == PH_PRESSREL)) begin
						if (item.button == BTN_WHEEL_UP || item.button == BTN_WHEEL_DOWN) begin
							phase_d[i] = PH_PRESSED;
							press_d[i] = '0;
						end else if (within_interval) begin
							phase_d[i] = PH_DCLICK;
							press_d[i] = '0;
						end else begin
							phase_d[i] = PH_PRESSED;
							press_d[i] = item.event_time;
						end
						if (item.button < BTN_FIRST_WHEEL) begin
							drag_btn_d = item.button;
							start_x_d  = cur_x_q;
							start_y_d  = cur_y_q;
						end
					end
				end
			end
			OP_UP: begin
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					if (item.btn_valid && item.button == 3'(i)) begin
						if (phase_q[i] == PH_PRESSED) begin
							phase_d[i] = PH_PRESSREL;
						end else if (phase_q[i] == PH_DOWN || phase_q[i] == PH_DRAG ||
						             phase_q[i] == PH_DCLICK) begin
							phase_d[i] = PH_RELEASED;
						end
					end
				end
			end
			OP_MOTION: begin
				// Pointer motion is dropped while the middle button is in any phase but up.
				if (phase_q[BTN_MIDDLE] == PH_UP) begin
					cur_x_d = item.pos_x;
					cur_y_d = item.pos_y;
					for (int i = 0; i < NUM_BUTTONS; i++) begin
						if (drag_btn_q == 3'(i) && moved_far &&
						    (phase_q[i] == PH_PRESSED || phase_q[i] == PH_DOWN)) begin
							phase_d[i] = PH_DRAG;
						end
					end
				end
			end
			OP_TICK: begin
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					if (phase_q[i] == PH_PRESSED) begin
						phase_d[i] = PH_DOWN;
					end else if (phase_q[i] == PH_RELEASED || phase_q[i] == PH_DCLICK ||
					             phase_q[i] == PH_PRESSREL) begin
						phase_d[i] = PH_UP;
					end
				end
			end
			OP_FOCUS: begin
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					phase_d[i] = PH_RELEASED;
				end
			end
			default: begin
			end
		endcase
	end

	// The result reports the addressed button after the event has been applied.
	always_comb begin
		res_phase = PH_UP;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (item.btn_valid && item.button == 3'(i)) begin
				res_phase = phase_d[i];
			end
		end
		res.button_phase   = res_phase;
		res.is_down        = (res_phase != PH_UP);
		res.went_down      = (res_phase == PH_PRESSED || res_phase == PH_DCLICK ||
		                      res_phase == PH_PRESSREL);
		res.went_up        = (res_phase == PH_RELEASED || res_phase == PH_DCLICK ||
		                      res_phase == PH_PRESSREL);
		res.double_clicked = (res_phase == PH_DCLICK);
		res.dragging       = (res_phase == PH_DRAG);
		res.drag_start_x   = (res_phase == PH_DRAG) ? start_x_d : 16'd0;
		res.drag_start_y   = (res_phase == PH_DRAG) ? start_y_d : 16'd0;
		res.pointer_x      = cur_x_d;
		res.pointer_y      = cur_y_d;
	end

	assign empty    = (count_q == 2'd0);
	assign do_pop   = pop && !empty;
	assign take     = !item_empty && ((count_q != 2'd2) || do_pop);
	assign item_pop = take;
	assign result   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (take) begin
			slot_q[wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= INTERVAL_RST;
			threshold_q <= THRESHOLD_RST;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				phase_q[i] <= PH_UP;
				press_q[i] <= '0;
			end
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			drag_btn_q <= DRAG_BTN_RST;
			start_x_q  <= '0;
			start_y_q  <= '0;
			wr_q       <= 1'b0;
			rd_q       <= 1'b0;
			count_q    <= 2'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INTERVAL:  interval_q  <= cfg_data;
					CFG_THRESHOLD: threshold_q <= cfg_data;
					default:       interval_q  <= interval_q;
				endcase
			end
			if (take) begin
				phase_q    <= phase_d;
				press_q    <= press_d;
				cur_x_q    <= cur_x_d;
				cur_y_q    <= cur_y_d;
				drag_btn_q <= drag_btn_d;
				start_x_q  <= start_x_d;
				start_y_q  <= start_y_d;
				wr_q       <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			case ({take, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/mouse_button_click_drag_tracker.sv
// Top level of the mouse button click and drag tracker.
//
// Events enter through a queue-style port: a transaction happens when push is
// high and full is low. Each event yields exactly one result transaction, read
// from the result ports while empty is low and taken when pop is high.
// The front end decodes the event into a two-entry queue; the back end applies
// it to the six button phase registers and the pointer and drag registers,
// and writes the result into a two-entry output queue.
// An event is registered into the input queue, then applied and registered
// into the output queue before empty goes low for its result. Throughput is
// one event per cycle while the receiver keeps popping.
// When the receiver stops popping, the output queue fills, the back end holds,
// the input queue fills behind it and full rises; nothing is lost.
// Reset clears both queues, sets every button to up, clears press times and
// positions, selects the left button for drag tracking and loads the register
// defaults (interval 250 ms, threshold 5 pixels). Write registers through
// cfg_we, cfg_index and cfg_data only while no transaction is in flight.
`timescale 1ns / 1ps

module mouse_button_click_drag_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  command,
	input  logic [2:0]  button,
	input  logic [31:0] event_time,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  button_phase,
	output logic        is_down,
	output logic        went_down,
	output logic        went_up,
	output logic        double_clicked,
	output logic        dragging,
	output logic [15:0] drag_start_x,
	output logic [15:0] drag_start_y,
	output logic [15:0] pointer_x,
	output logic [15:0] pointer_y
);
	import mbt_pkg::*;

	item_t   item;
	logic    item_empty;
	logic    item_pop;
	result_t result;

	mbt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.button     (button),
		.event_time (event_time),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.item_empty (item_empty),
		.item_pop   (item_pop),
		.item       (item)
	);

	mbt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_empty (item_empty),
		.item_pop   (item_pop),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

	assign button_phase   = result.button_phase;
	assign is_down        = result.is_down;
	assign went_down      = result.went_down;
	assign went_up        = result.went_up;
	assign double_clicked = result.double_clicked;
	assign dragging       = result.dragging;
	assign drag_start_x   = result.drag_start_x;
	assign drag_start_y   = result.drag_start_y;
	assign pointer_x      = result.pointer_x;
	assign pointer_y      = result.pointer_y;

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the mouse button click and drag tracker.
`timescale 1ns / 1ps

module tb_top;
	import mbt_pkg::*;

	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;
	localparam logic [2:0] BTN_LEFT    = 3'd1;
	localparam logic [2:0] BTN_RIGHT   = 3'd3;

	localparam int RANDOM_ITEMS = 825;
	localparam int NUM_SETTINGS = 5;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [2:0]  btn;
		logic [31:0] stamp;
		logic [15:0] x;
		logic [15:0] y;
	} mouse_ev_t;

	// Tracks the button phases, pointer and drag registers and holds the
	// reports that the block still owes, oldest first.
	class click_tracker_model;
		logic [15:0] interval;
		logic [15:0] threshold;
		logic [2:0]  phase [NUM_BUTTONS];
		logic [31:0] press_stamp [NUM_BUTTONS];
		logic [15:0] cur_x, cur_y, start_x, start_y;
		logic [2:0]  drag_btn;
		result_t     phase_reports[$];
		int          mismatches;

		function new();
			interval = INTERVAL_RST;
			threshold = THRESHOLD_RST;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				phase[i] = PH_UP;
				press_stamp[i] = '0;
			end
			cur_x = '0;
			cur_y = '0;
			start_x = '0;
			start_y = '0;
			drag_btn = DRAG_BTN_RST;
			mismatches = 0;
		endfunction

		function void set_reg(logic idx, logic [15:0] val);
			if (idx == CFG_INTERVAL)
				interval = val;
			else
				threshold = val;
		endfunction

		function logic [15:0] offset(logic [15:0] a, logic [15:0] b);
			return (a > b) ? a - b : b - a;
		endfunction

		function void apply_event(mouse_ev_t ev);
			logic [2:0]  p;
			logic [31:0] elapsed;
			logic        in_range;
			result_t     r;
			in_range = (ev.btn < NUM_BUTTONS);
			case (ev.cmd)
				CMD_DOWN: begin
					if (in_range && (phase[ev.btn] == PH_UP || phase[ev.btn] == PH_RELEASED ||
							phase[ev.btn] == PH_PRESSREL)) begin
						// Wrapping difference, so a press just after the counter rolls
						// over can still complete a double click.
						elapsed = ev.stamp - press_stamp[ev.btn];
						if (ev.btn == BTN_WHEEL_UP || ev.btn == BTN_WHEEL_DOWN) begin
							phase[ev.btn] = PH_PRESSED;
							press_stamp[ev.btn] = '0;
						end else if (elapsed < {16'd0, interval}) begin
							phase[ev.btn] = PH_DCLICK;
							press_stamp[ev.btn] = '0;
						end else begin
							phase[ev.btn] = PH_PRESSED;
							press_stamp[ev.btn] = ev.stamp;
						end
						if (ev.btn < BTN_FIRST_WHEEL) begin
							drag_btn = ev.btn;
							start_x = cur_x;
							start_y = cur_y;
						end
					end
				end
				CMD_UP: begin
					if (in_range) begin
						p = phase[ev.btn];
						if (p == PH_PRESSED)
							phase[ev.btn] = PH_PRESSREL;
						else if (p == PH_DOWN || p == PH_DRAG || p == PH_DCLICK)
							phase[ev.btn] = PH_RELEASED;
					end
				end
				CMD_MOTION: begin
					if (phase[BTN_MIDDLE] == PH_UP) begin
						cur_x = ev.x;
						cur_y = ev.y;
						if (drag_btn < NUM_BUTTONS) begin
							p = phase[drag_btn];
							if ((p == PH_PRESSED || p == PH_DOWN) &&
									(offset(start_x, cur_x) > threshold ||
									offset(start_y, cur_y) > threshold))
								phase[drag_btn] = PH_DRAG;
						end
					end
				end
				CMD_TICK: begin
					for (int i = 0; i < NUM_BUTTONS; i++) begin
						if (phase[i] == PH_PRESSED)
							phase[i] = PH_DOWN;
						else if (phase[i] == PH_RELEASED || phase[i] == PH_DCLICK ||
								phase[i] == PH_PRESSREL)
							phase[i] = PH_UP;
					end
				end
				CMD_FOCUS: begin
					for (int i = 0; i < NUM_BUTTONS; i++)
						phase[i] = PH_RELEASED;
				end
				default: ;
			endcase

			p = in_range ? phase[ev.btn] : PH_UP;
			r.button_phase = p;
			r.is_down = (p != PH_UP);
			r.went_down = (p == PH_PRESSED || p == PH_DCLICK || p == PH_PRESSREL);
			r.went_up = (p == PH_RELEASED || p == PH_DCLICK || p == PH_PRESSREL);
			r.double_clicked = (p == PH_DCLICK);
			r.dragging = (p == PH_DRAG);
			r.drag_start_x = r.dragging ? start_x : 16'd0;
			r.drag_start_y = r.dragging ? start_y : 16'd0;
			r.pointer_x = cur_x;
			r.pointer_y = cur_y;
			phase_reports.push_back(r);
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_report(result_t act);
			result_t e;
			if (phase_reports.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result transaction, phase expected none actual %0d",
					$time, act.button_phase);
				return;
			end
			e = phase_reports.pop_front();
			compare("button_phase", e.button_phase, act.button_phase);
			compare("is_down", e.is_down, act.is_down);
			compare("went_down", e.went_down, act.went_down);
			compare("went_up", e.went_up, act.went_up);
			compare("double_clicked", e.double_clicked, act.double_clicked);
			compare("dragging", e.dragging, act.dragging);
			compare("drag_start_x", e.drag_start_x, act.drag_start_x);
			compare("drag_start_y", e.drag_start_y, act.drag_start_y);
			compare("pointer_x", e.pointer_x, act.pointer_x);
			compare("pointer_y", e.pointer_y, act.pointer_y);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        push;
	logic        full;
	logic [2:0]  command;
	logic [2:0]  button;
	logic [31:0] event_time;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic        empty;
	logic        pop;
	logic [2:0]  button_phase;
	logic        is_down;
	logic        went_down;
	logic        went_up;
	logic        double_clicked;
	logic        dragging;
	logic [15:0] drag_start_x;
	logic [15:0] drag_start_y;
	logic [15:0] pointer_x;
	logic [15:0] pointer_y;

	click_tracker_model tracker;
	int          cycles = 0;
	int          items_sent;
	int          burst_left;
	logic [31:0] now_ms;

	mouse_button_click_drag_tracker DUT (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: switches at random between stall patterns, from popping every
	// cycle to long stretches of back pressure.
	initial begin
		int   rx_mode;
		int   rx_left;
		result_t got;
		pop = 1'b0;
		rx_mode = 0;
		rx_left = 0;
		forever begin
			@(negedge clk);
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_left = $urandom_range(16, 96);
			end
			rx_left--;
			case (rx_mode)
				0: pop = 1'b1;
				1: pop = 1'($urandom_range(0, 1));
				default: pop = ($urandom_range(0, 7) == 0);
			endcase
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				got = {button_phase, is_down, went_down, went_up, double_clicked, dragging,
					drag_start_x, drag_start_y, pointer_x, pointer_y};
				tracker.check_report(got);
			end
		end
	end

	function automatic mouse_ev_t mk(logic [2:0] c, logic [2:0] b, logic [31:0] s,
			logic [15:0] x, logic [15:0] y);
		mouse_ev_t ev;
		ev.cmd = c;
		ev.btn = b;
		ev.stamp = s;
		ev.x = x;
		ev.y = y;
		return ev;
	endfunction

	// Sends one event and waits for its transaction; between bursts push sometimes
	// drops low before the next event.
	task automatic send_ev(mouse_ev_t ev);
		int gap;
		@(negedge clk);
		command = ev.cmd;
		button = ev.btn;
		event_time = ev.stamp;
		pos_x = ev.x;
		pos_y = ev.y;
		push = 1'b1;
		do @(posedge clk); while (full);
		tracker.apply_event(ev);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 6);
				@(negedge clk);
				push = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic settle();
		@(negedge clk);
		push = 1'b0;
		while (tracker.phase_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.set_reg(idx, val);
	endtask

	task automatic press(logic [2:0] b);
		int unsigned reach;
		reach = (tracker.interval > 1500) ? 3000 : 2 * tracker.interval + 10;
		if ($urandom_range(0, 9) == 0)
			now_ms = $urandom;
		else
			now_ms = now_ms + $urandom_range(0, reach);
		send_ev(mk(CMD_DOWN, b, now_ms, 16'($urandom), 16'($urandom)));
	endtask

	// Motion mostly lands near the current pointer, spread around the threshold,
	// so that drags start on some moves and not on others.
	task automatic motion(logic [2:0] b);
		int span;
		int nx;
		int ny;
		if ($urandom_range(0, 6) == 0) begin
			send_ev(mk(CMD_MOTION, b, $urandom, 16'($urandom), 16'($urandom)));
		end else begin
			span = (tracker.threshold > 1000) ? 1000 : tracker.threshold + 3;
			nx = int'(tracker.cur_x) + int'($urandom_range(0, 2 * span)) - span;
			ny = int'(tracker.cur_y) + int'($urandom_range(0, 2 * span)) - span;
			if (nx < 0) nx = 0;
			if (nx > 65535) nx = 65535;
			if (ny < 0) ny = 0;
			if (ny > 65535) ny = 65535;
			send_ev(mk(CMD_MOTION, b, $urandom, nx[15:0], ny[15:0]));
		end
	endtask

	function automatic logic [2:0] gesture_btn();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return BTN_LEFT;
		else if (r < 70) return BTN_RIGHT;
		else if (r < 80) return 3'd0;
		else if (r < 87) return BTN_MIDDLE;
		else if (r < 94) return BTN_WHEEL_UP;
		else return BTN_WHEEL_DOWN;
	endfunction

	// A press, some moves and frame ticks, a release, and sometimes a quick
	// second click on the same button.
	task automatic gesture();
		logic [2:0] b;
		int         n;
		b = gesture_btn();
		press(b);
		n = $urandom_range(0, 6);
		repeat (n) begin
			if ($urandom_range(0, 4) == 0)
				send_ev(mk(CMD_TICK, b, $urandom, 16'($urandom), 16'($urandom)));
			else
				motion(b);
		end
		send_ev(mk(CMD_UP, b, $urandom, 16'($urandom), 16'($urandom)));
		if ($urandom_range(0, 1) == 1)
			send_ev(mk(CMD_TICK, b, $urandom, 16'($urandom), 16'($urandom)));
		if ($urandom_range(0, 2) == 0) begin
			press(b);
			send_ev(mk(CMD_UP, b, $urandom, 16'($urandom), 16'($urandom)));
			send_ev(mk(CMD_TICK, b, $urandom, 16'($urandom), 16'($urandom)));
		end
	endtask

	task automatic noise();
		mouse_ev_t ev;
		ev = mk(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom,
			16'($urandom), 16'($urandom));
		if (ev.cmd == CMD_MOTION && $urandom_range(0, 1) == 1)
			motion(ev.btn);
		else
			send_ev(ev);
	endtask

	initial begin
		int quota;
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_INTERVAL;
		cfg_data = '0;
		push = 1'b0;
		command = CMD_STATUS;
		button = '0;
		event_time = '0;
		pos_x = '0;
		pos_y = '0;
		items_sent = 0;
		burst_left = 0;
		now_ms = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, with the register defaults.
		send_ev(mk(CMD_STATUS, 3'd0, 32'd0, 16'd0, 16'd0));
		send_ev(mk(CMD_DOWN, BTN_LEFT, 32'd1000, 16'hFFFF, 16'hFFFF));
		send_ev(mk(CMD_DOWN, BTN_LEFT, 32'd1010, 16'd0, 16'd0));
		// A move of exactly the threshold must not start a drag; one more pixel does.
		send_ev(mk(CMD_MOTION, BTN_LEFT, 32'hFFFF_FFFF, 16'd5, 16'd5));
		send_ev(mk(CMD_MOTION, BTN_LEFT, 32'd0, 16'd0, 16'd6));
		send_ev(mk(CMD_UP, BTN_LEFT, 32'd0, 16'd0, 16'd0));
		send_ev(mk(CMD_TICK, BTN_LEFT, 32'd0, 16'd0, 16'd0));
		send_ev(mk(CMD_DOWN, BTN_LEFT, 32'd1249, 16'd0, 16'd0));
		send_ev(mk(CMD_UP, BTN_LEFT, 32'd0, 16'd0, 16'd0));
		send_ev(mk(CMD_TICK, BTN_LEFT, 32'd0, 16'd0, 16'd0));
		// With the middle button held, motion leaves the pointer alone.
		send_ev(mk(CMD_DOWN, BTN_MIDDLE, 32'd7, 16'd0, 16'd0));
		send_ev(mk(CMD_MOTION, BTN_MIDDLE, 32'd0, 16'hFFFF, 16'hFFFF));
		send_ev(mk(CMD_UP, BTN_MIDDLE, 32'd0, 16'd0, 16'd0));
		send_ev(mk(CMD_TICK, BTN_MIDDLE, 32'd0, 16'd0, 16'd0));
		send_ev(mk(CMD_MOTION, BTN_LEFT, 32'd0, 16'hFFFF, 16'hFFFF));
		send_ev(mk(CMD_DOWN, BTN_WHEEL_UP, 32'hFFFF_FFFF, 16'd0, 16'd0));
		send_ev(mk(CMD_DOWN, BTN_WHEEL_DOWN, 32'd0, 16'd0, 16'd0));
		send_ev(mk(CMD_TICK, BTN_WHEEL_UP, 32'd0, 16'd0, 16'd0));
		send_ev(mk(CMD_FOCUS, BTN_RIGHT, 32'd0, 16'd0, 16'd0));
		// Double click across the wrap of the millisecond counter.
		send_ev(mk(CMD_DOWN, BTN_RIGHT, 32'hFFFF_FFA0, 16'd0, 16'd0));
		send_ev(mk(CMD_UP, BTN_RIGHT, 32'd0, 16'd0, 16'd0));
		send_ev(mk(CMD_DOWN, BTN_RIGHT, 32'd20, 16'd0, 16'd0));
		send_ev(mk(CMD_DOWN, 3'd6, 32'd0, 16'd0, 16'd0));
		send_ev(mk(CMD_UP, 3'd7, 32'd0, 16'd0, 16'd0));
		send_ev(mk(CMD_SPARE_A, 3'd0, 32'd0, 16'd0, 16'd0));
		send_ev(mk(CMD_SPARE_B, BTN_WHEEL_DOWN, 32'd0, 16'd0, 16'd0));
		send_ev(mk(CMD_TICK, 3'd6, 32'd0, 16'd0, 16'd0));
		send_ev(mk(CMD_MOTION, 3'd6, 32'd0, 16'h1234, 16'hEDCB));
		settle();

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			case (s)
				0: begin
					write_reg(CFG_INTERVAL, INTERVAL_RST);
					write_reg(CFG_THRESHOLD, THRESHOLD_RST);
				end
				1: begin
					write_reg(CFG_INTERVAL, 16'd0);
					write_reg(CFG_THRESHOLD, 16'd0);
				end
				2: begin
					write_reg(CFG_INTERVAL, 16'hFFFF);
					write_reg(CFG_THRESHOLD, 16'hFFFF);
				end
				3: begin
					write_reg(CFG_INTERVAL, 16'($urandom_range(50, 600)));
					write_reg(CFG_THRESHOLD, 16'($urandom_range(1, 40)));
				end
				default: begin
					write_reg(CFG_INTERVAL, 16'd1);
					write_reg(CFG_THRESHOLD, 16'd1);
				end
			endcase
			quota = items_sent + RANDOM_ITEMS / NUM_SETTINGS;
			while (items_sent < quota) begin
				if ($urandom_range(0, 3) != 0)
					gesture();
				else
					noise();
			end
			settle();
		end

		if (tracker.mismatches == 0 && tracker.phase_reports.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
